// ===== design/olst_pkg.sv =====
// shared codes, field widths and cell control type for the ordered list store
package olst_pkg;

    // field widths of the command and result ports
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // widest stored value
    localparam int WIDE_W = 64;

    // default configuration
    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // per-cell operation codes
    localparam logic [1:0] OP_HOLD     = 2'd0;
    localparam logic [1:0] OP_LOAD     = 2'd1;
    localparam logic [1:0] OP_SHIFT_UP = 2'd2;
    localparam logic [1:0] OP_SHIFT_DN = 2'd3;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic [1:0] op;
        logic       rd;
    } t_cell_ctl;

endpackage

// ===== design/olst_cell.sv =====
// one list slot: holds an entry, loads, shifts with its neighbors, drives its read lane
module olst_cell #(
    parameter int INDEX = 0,
    parameter int TW    = 9,
    parameter int VW    = 32
) (
    input  logic                i_clk,
    input  olst_pkg::t_cell_ctl i_ctl,
    input  logic [TW-1:0]       i_tgt,
    input  logic [VW-1:0]       i_value,
    input  logic [VW-1:0]       i_left,
    input  logic [VW-1:0]       i_right,
    output logic [VW-1:0]       o_value,
    output logic [VW-1:0]       o_rd
);

    localparam logic [TW-1:0] MY_IDX = TW'(INDEX);

    logic [VW-1:0] r_value;
    logic [VW-1:0] n_value;
    logic [VW-1:0] r_rd;
    logic          match;
    logic          above;

    assign match = (i_tgt == MY_IDX);
    assign above = (MY_IDX > i_tgt);

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            olst_pkg::OP_LOAD: begin
                if (match) n_value = i_value;
            end
            olst_pkg::OP_SHIFT_UP: begin
                if (match) n_value = i_value;
                else if (above) n_value = i_left;
            end
            olst_pkg::OP_SHIFT_DN: begin
                if (match || above) n_value = i_right;
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_rd    <= (i_ctl.rd && match) ? r_value : '0;
    end

    assign o_value = r_value;
    assign o_rd    = r_rd;

endmodule

// ===== design/ordered_list_store.sv =====
// top level of the ordered list store: command decode, row of cells, result stage
//
// ordered list of up to CAPACITY entries kept in a row of cells, one entry
// per cell. every command (append, insert, replace, get, remove) is applied
// to the row when it is accepted: insert and remove move all later entries
// by one slot at once, each cell loading from its left or right neighbor.
// a new request is taken every clock cycle while busy is low; busy is high
// during reset and until the ready register is set after it. each request
// gives exactly one result, shown for one cycle: the request is registered
// into the first stage and then into the result stage, which raises o_valid.
// the first stage gates the addressed cell onto its read lane, the second
// merges the lanes of the whole row and registers the result. the receiver
// cannot stall, so results must be taken when o_valid is high. entries above
// the count hold stale data and are never returned.
module ordered_list_store #(
    parameter int CAPACITY    = olst_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = olst_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [olst_pkg::CMD_W-1:0]    i_command,
    input  logic [olst_pkg::POS_W-1:0]    i_position,
    input  logic [olst_pkg::DATA_W-1:0]   i_element_value,
    output logic                          o_valid,
    output logic [olst_pkg::STATUS_W-1:0] o_status,
    output logic [olst_pkg::DATA_W-1:0]   o_read_value,
    output logic [olst_pkg::COUNT_W-1:0]  o_entry_count
);

    // count width holds 0..CAPACITY; compare width also covers the position
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int TW        = (CNT_W > olst_pkg::POS_W) ? CNT_W : olst_pkg::POS_W;
    localparam int CNT_EXT_W = (CNT_W > olst_pkg::COUNT_W) ? CNT_W : olst_pkg::COUNT_W;
    localparam logic [TW-1:0] CAP_X = TW'(CAPACITY);

    // control registers
    logic                          r_ready;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic                          r_pend;
    logic [olst_pkg::STATUS_W-1:0] r_status;
    logic [olst_pkg::STATUS_W-1:0] n_status;

    // result stage
    logic                          r_out_valid;
    logic [olst_pkg::STATUS_W-1:0] r_out_status;
    logic [olst_pkg::DATA_W-1:0]   r_out_value;
    logic [olst_pkg::COUNT_W-1:0]  r_out_count;

    // decode
    logic                  accept;
    logic [TW-1:0]         pos_x;
    logic [TW-1:0]         cnt_x;
    logic                  full;
    logic                  pos_in_list;
    logic                  pos_insertable;
    olst_pkg::t_cell_ctl   cell_ctl;
    logic [TW-1:0]         cell_tgt;
    logic [VALUE_WIDTH-1:0] cell_value;
    logic [olst_pkg::WIDE_W-1:0] value_ext;

    // row wiring
    logic [VALUE_WIDTH-1:0] w_val [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_rd  [CAPACITY];
    logic [VALUE_WIDTH-1:0] rd_or;
    logic [olst_pkg::WIDE_W-1:0] rd_ext;
    logic [CNT_EXT_W-1:0]   cnt_ext;

    assign busy   = ~r_ready;
    assign accept = start & r_ready;

    assign pos_x          = TW'(i_position);
    assign cnt_x          = TW'(r_count);
    assign full           = (cnt_x == CAP_X);
    assign pos_in_list    = (pos_x < cnt_x);
    assign pos_insertable = (pos_x <= cnt_x);

    // incoming value kept at VALUE_WIDTH bits
    assign value_ext  = olst_pkg::WIDE_W'(i_element_value);
    assign cell_value = value_ext[VALUE_WIDTH-1:0];

    // command decode: status, new count and the operation broadcast to the row
    always_comb begin
        n_status    = olst_pkg::ST_OK;
        n_count     = r_count;
        cell_ctl.op = olst_pkg::OP_HOLD;
        cell_ctl.rd = 1'b0;
        cell_tgt    = pos_x;
        if (accept) begin
            case (i_command)
                olst_pkg::CMD_APPEND: begin
                    if (full) begin
                        n_status = olst_pkg::ST_FULL;
                    end else begin
                        cell_ctl.op = olst_pkg::OP_LOAD;
                        cell_tgt    = cnt_x;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                olst_pkg::CMD_INSERT: begin
                    // range check wins over the full check
                    if (!pos_insertable) begin
                        n_status = olst_pkg::ST_RANGE;
                    end else if (full) begin
                        n_status = olst_pkg::ST_FULL;
                    end else begin
                        cell_ctl.op = olst_pkg::OP_SHIFT_UP;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                olst_pkg::CMD_REPLACE: begin
                    if (!pos_in_list) n_status = olst_pkg::ST_RANGE;
                    else cell_ctl.op = olst_pkg::OP_LOAD;
                end
                olst_pkg::CMD_GET: begin
                    if (!pos_in_list) n_status = olst_pkg::ST_RANGE;
                    else cell_ctl.rd = 1'b1;
                end
                olst_pkg::CMD_REMOVE: begin
                    if (!pos_in_list) begin
                        n_status = olst_pkg::ST_RANGE;
                    end else begin
                        cell_ctl.op = olst_pkg::OP_SHIFT_DN;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                // unused codes leave everything alone
                default: n_status = olst_pkg::ST_OK;
            endcase
        end
    end

    // row of cells, each wired to its neighbors; the ends see themselves
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_v;
        logic [VALUE_WIDTH-1:0] right_v;
        if (k == 0) begin : g_first
            assign left_v = w_val[k];
        end else begin : g_mid_l
            assign left_v = w_val[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_v = w_val[k];
        end else begin : g_mid_r
            assign right_v = w_val[k+1];
        end
        olst_cell #(
            .INDEX (k),
            .TW    (TW),
            .VW    (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_tgt   (cell_tgt),
            .i_value (cell_value),
            .i_left  (left_v),
            .i_right (right_v),
            .o_value (w_val[k]),
            .o_rd    (w_rd[k])
        );
    end

    // read lanes are zero except at the addressed cell of a good get
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | w_rd[k];
        end
    end

    assign rd_ext  = olst_pkg::WIDE_W'(rd_or);
    assign cnt_ext = CNT_EXT_W'(r_count);

    // first stage: list state and status of the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_count <= n_count;
            r_pend  <= accept;
        end
        r_status <= n_status;
    end

    // second stage: merged read lanes, status and count go out for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_pend;
        end
        r_out_status <= r_status;
        r_out_value  <= rd_ext[olst_pkg::DATA_W-1:0];
        r_out_count  <= cnt_ext[olst_pkg::COUNT_W-1:0];
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_value;
    assign o_entry_count = r_out_count;

`ifndef SYNTHESIS
    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_x <= CAP_X)
        else $error("entry count above capacity");

    // every accepted request is followed by a result on o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("request without result");

    // a full status only when the list is at capacity and stays there
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_status == olst_pkg::ST_FULL) |-> (cnt_x == CAP_X))
        else $error("full status with room left");

    // failed requests never return data
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != olst_pkg::ST_OK) |-> (o_read_value == '0))
        else $error("data returned on failed request");
`endif

endmodule
